FILE: rtl/core/hcpm_pkg.sv
// Shared types and constants for the heating-curve PI mixer controller.
package hcpm_pkg;

   localparam int HCPM_FROST_THRESHOLD = 30;

   localparam int TEMP_W      = 12;
   localparam int ROOM_W      = 9;
   localparam int DRIVE_W     = 15;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [DRIVE_W-1:0]       DRIVE_MAX   = 15'd25600;
   localparam logic [DRIVE_W-1:0]       DRIVE_RESET = 15'd12800;
   localparam logic signed [TEMP_W-1:0] SP_PUMP_MIN = 12'sd200;
   localparam logic signed [10:0]       HYST_BAND   = 11'sd10;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CURVE_SLOPE    = 3'd0,
      REG_CURVE_OFFSET   = 3'd1,
      REG_SETBACK        = 3'd2,
      REG_FLOW_MIN       = 3'd3,
      REG_FLOW_MAX       = 3'd4,
      REG_PROP_GAIN      = 3'd5,
      REG_INTEGRAL_GAIN  = 3'd6,
      REG_HEAT_START     = 3'd7
   } hcpm_reg_type;

   // One strobe per datapath step
   typedef struct packed {
      logic capture;
      logic slope_mul;
      logic setpoint;
      logic clamp;
      logic p_mul;
      logic i_mul;
      logic drive;
   } hcpm_cmd_type;

endpackage

FILE: rtl/core/hcpm_ifs.sv
// Handshake channel interfaces: input items, result items, register writes.
interface hcpm_req_if import hcpm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] outdoor_temp;
   logic signed [TEMP_W-1:0] outdoor_average;
   logic signed [TEMP_W-1:0] flow_temp;
   logic [ROOM_W-1:0]        room_setpoint;
   logic                     reduced_mode;
   logic                     party_active;

   modport source (output valid, outdoor_temp, outdoor_average, flow_temp,
                   room_setpoint, reduced_mode, party_active, input ready);
   modport sink   (input valid, outdoor_temp, outdoor_average, flow_temp,
                   room_setpoint, reduced_mode, party_active, output ready);
endinterface

interface hcpm_rsp_if import hcpm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] flow_setpoint;
   logic [DRIVE_W-1:0]       valve_position;
   logic                     pump_on;

   modport source (output valid, flow_setpoint, valve_position, pump_on, input ready);
   modport sink   (input valid, flow_setpoint, valve_position, pump_on, output ready);
endinterface

interface hcpm_csr_if import hcpm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/hcpm_ctrl.sv
// Step sequencer: walks one item through the datapath and owns the result valid flag.
module hcpm_ctrl import hcpm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output hcpm_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SLOPE,
      ST_SETPT,
      ST_CLAMP,
      ST_PMUL,
      ST_IMUL,
      ST_DRIVE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // result slot is free when empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_SLOPE;
            end
         end
         ST_SLOPE: begin
            cmd.slope_mul = 1'b1;
            state_in      = ST_SETPT;
         end
         ST_SETPT: begin
            cmd.setpoint = 1'b1;
            state_in     = ST_CLAMP;
         end
         ST_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = ST_PMUL;
         end
         ST_PMUL: begin
            cmd.p_mul = 1'b1;
            state_in  = ST_IMUL;
         end
         ST_IMUL: begin
            cmd.i_mul = 1'b1;
            state_in  = ST_DRIVE;
         end
         ST_DRIVE: begin
            if (out_free) begin
               cmd.drive    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/core/hcpm_dp.sv
// Datapath: config registers, heating curve, setpoint clamp, velocity PI, pump logic.
module hcpm_dp import hcpm_pkg::*; #(
   parameter int FROST_THRESHOLD = HCPM_FROST_THRESHOLD
) (
   input  logic                     clock,
   input  logic                     reset,
   input  hcpm_cmd_type             cmd,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data,
   input  logic signed [TEMP_W-1:0] in_outdoor_temp,
   input  logic signed [TEMP_W-1:0] in_outdoor_average,
   input  logic signed [TEMP_W-1:0] in_flow_temp,
   input  logic [ROOM_W-1:0]        in_room_setpoint,
   input  logic                     in_reduced_mode,
   input  logic                     in_party_active,
   output logic signed [TEMP_W-1:0] flow_setpoint,
   output logic [DRIVE_W-1:0]       valve_position,
   output logic                     pump_on
);

   localparam logic signed [TEMP_W-1:0] FROST_C = TEMP_W'(FROST_THRESHOLD);

   // configuration
   logic [10:0]        slope_ff;
   logic signed [9:0]  offset_ff;
   logic [8:0]         setback_ff;
   logic signed [11:0] fmin_ff, fmax_ff;
   logic [15:0]        kp_ff, ki_ff;
   logic signed [9:0]  start_ff;

   // captured item
   logic signed [TEMP_W-1:0] outdoor_ff, average_ff, flow_ff;
   logic [ROOM_W-1:0]        room_ff;
   logic                     setback_on_ff;

   // work registers
   logic signed [12:0] diff_ff, diff_in;
   logic signed [24:0] curve_ff, curve_in;
   logic signed [16:0] sp_raw_ff, sp_raw_in;
   logic signed [11:0] sp_ff, sp_in;
   logic signed [12:0] err_ff, err_in;
   logic signed [30:0] p_term_ff, p_term_in;
   logic signed [29:0] i_term_ff, i_term_in;

   // controller state
   logic signed [12:0]  prev_err_ff;
   logic [DRIVE_W-1:0]  prev_drive_ff, drive_in;
   logic                pump_ff, pump_in;

   logic signed [TEMP_W-1:0] flow_setpoint_ff;
   logic [DRIVE_W-1:0]       valve_position_ff;

   logic signed [25:0] rounded;
   logic signed [16:0] sp_sum;
   logic signed [13:0] derr;
   logic signed [32:0] y_sum;
   logic signed [10:0] start_hi;

   always_comb begin
      diff_in  = $signed({4'b0, in_room_setpoint}) - 13'(in_outdoor_temp);
      curve_in = 25'(diff_ff) * 25'($signed({1'b0, slope_ff}));

      // round half up to 0.1 degC, floor shift
      rounded  = 26'(curve_ff) + 26'sd128;
      sp_sum   = rounded[24:8] + $signed({8'b0, room_ff}) + 17'(offset_ff);
      sp_raw_in = setback_on_ff ? sp_sum - $signed({8'b0, setback_ff}) : sp_sum;

      if (sp_raw_ff < 17'(fmin_ff)) begin
         sp_in = fmin_ff;
      end else if (sp_raw_ff > 17'(fmax_ff)) begin
         sp_in = fmax_ff;
      end else begin
         sp_in = sp_raw_ff[11:0];
      end
      err_in = 13'(sp_in) - 13'(flow_ff);

      derr      = 14'(err_ff) - 14'(prev_err_ff);
      p_term_in = 31'(derr) * 31'($signed({1'b0, kp_ff}));
      i_term_in = 30'(err_ff) * 30'($signed({1'b0, ki_ff}));

      y_sum = $signed({18'b0, prev_drive_ff}) + 33'(p_term_ff) + 33'(i_term_ff);
      if (y_sum <= 33'sd0) begin
         drive_in = '0;
      end else if (y_sum >= $signed({18'b0, DRIVE_MAX})) begin
         drive_in = DRIVE_MAX;
      end else begin
         drive_in = y_sum[DRIVE_W-1:0];
      end

      start_hi = 11'(start_ff) + HYST_BAND;
      if (12'(average_ff) < 12'(start_ff) && sp_ff > SP_PUMP_MIN) begin
         pump_in = 1'b1;
      end else if (12'(average_ff) > 12'(start_hi)) begin
         pump_in = 1'b0;
      end else if (outdoor_ff < FROST_C) begin
         pump_in = 1'b1;
      end else begin
         pump_in = pump_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slope_ff      <= 11'd256;
         offset_ff     <= 10'sd0;
         setback_ff    <= 9'd100;
         fmin_ff       <= 12'sd200;
         fmax_ff       <= 12'sd450;
         kp_ff         <= 16'd256;
         ki_ff         <= 16'd26;
         start_ff      <= 10'sd150;
         prev_err_ff   <= '0;
         prev_drive_ff <= DRIVE_RESET;
         pump_ff       <= 1'b0;
      end else begin
         if (csr_we) begin
            case (hcpm_reg_type'(csr_index))
               REG_CURVE_SLOPE:   slope_ff   <= csr_data[10:0];
               REG_CURVE_OFFSET:  offset_ff  <= csr_data[9:0];
               REG_SETBACK:       setback_ff <= csr_data[8:0];
               REG_FLOW_MIN:      fmin_ff    <= csr_data[11:0];
               REG_FLOW_MAX:      fmax_ff    <= csr_data[11:0];
               REG_PROP_GAIN:     kp_ff      <= csr_data;
               REG_INTEGRAL_GAIN: ki_ff      <= csr_data;
               REG_HEAT_START:    start_ff   <= csr_data[9:0];
               default: begin
               end
            endcase
         end
         if (cmd.drive) begin
            prev_err_ff   <= err_ff;
            prev_drive_ff <= drive_in;
            pump_ff       <= pump_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         outdoor_ff    <= in_outdoor_temp;
         average_ff    <= in_outdoor_average;
         flow_ff       <= in_flow_temp;
         room_ff       <= in_room_setpoint;
         setback_on_ff <= in_reduced_mode && !in_party_active;
         diff_ff       <= diff_in;
      end
      if (cmd.slope_mul) begin
         curve_ff <= curve_in;
      end
      if (cmd.setpoint) begin
         sp_raw_ff <= sp_raw_in;
      end
      if (cmd.clamp) begin
         sp_ff  <= sp_in;
         err_ff <= err_in;
      end
      if (cmd.p_mul) begin
         p_term_ff <= p_term_in;
      end
      if (cmd.i_mul) begin
         i_term_ff <= i_term_in;
      end
      if (cmd.drive) begin
         flow_setpoint_ff  <= sp_ff;
         valve_position_ff <= drive_in;
      end
   end

   assign flow_setpoint  = flow_setpoint_ff;
   assign valve_position = valve_position_ff;
   assign pump_on        = pump_ff;

endmodule

FILE: rtl/core/heating_curve_pi_mixer_control.sv
// Top level: weather-compensated flow setpoint with velocity PI mixing-valve drive.
//
// One item per sensor tick yields exactly one result: the clamped flow setpoint,
// the valve drive in 1/256 % (0..25600, anti-windup clamped) and the pump enable.
// An item passes from acceptance to the result register through the controller's
// step sequence (curve multiply, setpoint, clamp, P multiply, I multiply, drive
// update); the next item is accepted only once the sequencer is back in idle after
// the drive update, so items are not overlapped. A
// result waiting in the output register does not block the next item's work; the
// final step holds only if the previous result is still untaken. Register writes
// are taken every cycle and must only come while the block is idle.
module heating_curve_pi_mixer_control import hcpm_pkg::*; #(
   parameter int FROST_THRESHOLD = HCPM_FROST_THRESHOLD
) (
   input  logic        clock,
   input  logic        reset,
   hcpm_req_if.sink    req,
   hcpm_rsp_if.source  rsp,
   hcpm_csr_if.sink    csr
);

   hcpm_cmd_type cmd;
   logic         req_ready;
   logic         rsp_valid;

   assign req.ready = req_ready;
   assign rsp.valid = rsp_valid;
   assign csr.ready = 1'b1;

   hcpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   hcpm_dp #(
      .FROST_THRESHOLD (FROST_THRESHOLD)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .csr_we             (csr.valid),
      .csr_index          (csr.index),
      .csr_data           (csr.data),
      .in_outdoor_temp    (req.outdoor_temp),
      .in_outdoor_average (req.outdoor_average),
      .in_flow_temp       (req.flow_temp),
      .in_room_setpoint   (req.room_setpoint),
      .in_reduced_mode    (req.reduced_mode),
      .in_party_active    (req.party_active),
      .flow_setpoint      (rsp.flow_setpoint),
      .valve_position     (rsp.valve_position),
      .pump_on            (rsp.pump_on)
   );

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the heating-curve PI mixer controller.
module tb;
   import hcpm_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int QUIET_CYCLES   = 16;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_TICKS    = 170;
   localparam int EXTREME_TICKS  = 60;

   typedef struct {
      logic signed [TEMP_W-1:0] outdoor;
      logic signed [TEMP_W-1:0] average;
      logic signed [TEMP_W-1:0] flow;
      logic [ROOM_W-1:0]        room;
      logic                     reduced;
      logic                     party;
   } sensor_tick_type;

   typedef struct {
      logic signed [TEMP_W-1:0] setpoint;
      logic [DRIVE_W-1:0]       valve;
      logic                     pump;
   } ctrl_out_type;

   typedef enum {RX_ALWAYS, RX_RANDOM, RX_SPARSE} rx_pace_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #4 clock = ~clock;

   hcpm_req_if req_ch ();
   hcpm_rsp_if rsp_ch ();
   hcpm_csr_if csr_ch ();

   heating_curve_pi_mixer_control u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   // register mirror, reset values
   logic [10:0]        cfg_slope      = 11'd256;
   logic signed [9:0]  cfg_offset     = 10'sd0;
   logic [8:0]         cfg_setback    = 9'd100;
   logic signed [11:0] cfg_flow_min   = 12'sd200;
   logic signed [11:0] cfg_flow_max   = 12'sd450;
   logic [15:0]        cfg_kp         = 16'd256;
   logic [15:0]        cfg_ki         = 16'd26;
   logic signed [9:0]  cfg_heat_start = 10'sd150;

   // controller state mirror
   longint err_state   = 0;
   longint drive_state = longint'(DRIVE_RESET);
   logic   pump_state  = 1'b0;

   sensor_tick_type tick_q[$];
   ctrl_out_type    expected_ctrl_q[$];
   sensor_tick_type cur_tick;

   int burst_left     = 1;
   int gap_left       = 0;
   int stall_left     = 0;
   rx_pace_type rx_pace = RX_ALWAYS;
   int idle_cycles    = 0;
   int mismatch_count = 0;
   int ticks_sent     = 0;
   int results_checked = 0;
   int settings_used  = 0;
   int pump_on_count  = 0;
   int saturated_count = 0;

   function automatic ctrl_out_type compute_control(sensor_tick_type t);
      longint       rise;
      longint       sp;
      longint       err;
      longint       y;
      ctrl_out_type r;
      rise = (longint'(t.room) - longint'(t.outdoor)) * longint'(cfg_slope) + 128;
      sp = (rise >>> 8) + longint'(t.room) + longint'(cfg_offset);
      if (t.reduced && !t.party)
         sp -= longint'(cfg_setback);
      if (sp < longint'(cfg_flow_min))
         sp = longint'(cfg_flow_min);
      else if (sp > longint'(cfg_flow_max))
         sp = longint'(cfg_flow_max);
      err = sp - longint'(t.flow);
      y = drive_state + longint'(cfg_kp) * (err - err_state) + longint'(cfg_ki) * err;
      if (y <= 0)
         y = 0;
      else if (y >= longint'(DRIVE_MAX))
         y = longint'(DRIVE_MAX);
      drive_state = y;
      err_state = err;
      // start wins over stop, stop over frost, otherwise hold
      if (longint'(t.average) < longint'(cfg_heat_start) && sp > longint'(SP_PUMP_MIN))
         pump_state = 1'b1;
      else if (longint'(t.average) > longint'(cfg_heat_start) + longint'(HYST_BAND))
         pump_state = 1'b0;
      else if (longint'(t.outdoor) < longint'(HCPM_FROST_THRESHOLD))
         pump_state = 1'b1;
      r.setpoint = sp[TEMP_W-1:0];
      r.valve = y[DRIVE_W-1:0];
      r.pump = pump_state;
      return r;
   endfunction

   function automatic sensor_tick_type make_tick(int outdoor, int average, int flow, int room,
                                                 bit reduced, bit party);
      sensor_tick_type t;
      t.outdoor = TEMP_W'(outdoor);
      t.average = TEMP_W'(average);
      t.flow = TEMP_W'(flow);
      t.room = ROOM_W'(room);
      t.reduced = reduced;
      t.party = party;
      return t;
   endfunction

   function automatic sensor_tick_type random_tick();
      sensor_tick_type t;
      int              base;
      if ($urandom_range(0, 6) == 0) begin
         // raw bit patterns, out-of-range values included
         t.outdoor = TEMP_W'($urandom);
         t.average = TEMP_W'($urandom);
         t.flow = TEMP_W'($urandom);
         t.room = ROOM_W'($urandom);
         t.reduced = 1'($urandom);
         t.party = 1'($urandom);
      end else begin
         base = int'($urandom_range(0, 700)) - 250;
         t.outdoor = TEMP_W'(base);
         // keep the average near the start level often, to work the hysteresis band
         if ($urandom_range(0, 2) == 0)
            t.average = TEMP_W'(int'(cfg_heat_start) + int'($urandom_range(0, 30)) - 10);
         else
            t.average = TEMP_W'(base + int'($urandom_range(0, 120)) - 60);
         t.flow = TEMP_W'(int'($urandom_range(0, 800)) - 100);
         if ($urandom_range(0, 3) == 0)
            t.room = ROOM_W'($urandom_range(0, 400));
         else
            t.room = ROOM_W'($urandom_range(160, 240));
         t.reduced = 1'($urandom);
         t.party = ($urandom_range(0, 3) == 0);
      end
      return t;
   endfunction

   function automatic logic [15:0] maybe_raw(logic [15:0] v);
      return ($urandom_range(0, 4) == 0) ? 16'($urandom) : v;
   endfunction

   task automatic write_reg(hcpm_reg_type idx, logic [15:0] val);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      case (idx)
         REG_CURVE_SLOPE:   cfg_slope = val[10:0];
         REG_CURVE_OFFSET:  cfg_offset = val[9:0];
         REG_SETBACK:       cfg_setback = val[8:0];
         REG_FLOW_MIN:      cfg_flow_min = val[11:0];
         REG_FLOW_MAX:      cfg_flow_max = val[11:0];
         REG_PROP_GAIN:     cfg_kp = val;
         REG_INTEGRAL_GAIN: cfg_ki = val;
         REG_HEAT_START:    cfg_heat_start = val[9:0];
         default: ;
      endcase
   endtask

   task automatic program_setting(int slope, int offset, int setback, int fmin, int fmax,
                                  int kp, int ki, int start);
      write_reg(REG_CURVE_SLOPE, 16'(slope));
      write_reg(REG_CURVE_OFFSET, 16'(offset));
      write_reg(REG_SETBACK, 16'(setback));
      write_reg(REG_FLOW_MIN, 16'(fmin));
      write_reg(REG_FLOW_MAX, 16'(fmax));
      write_reg(REG_PROP_GAIN, 16'(kp));
      write_reg(REG_INTEGRAL_GAIN, 16'(ki));
      write_reg(REG_HEAT_START, 16'(start));
      settings_used++;
   endtask

   task automatic program_random_setting();
      int fmin;
      fmin = int'($urandom_range(0, 900)) - 500;
      write_reg(REG_CURVE_SLOPE, maybe_raw(16'($urandom_range(0, 2047))));
      write_reg(REG_CURVE_OFFSET, maybe_raw(16'(int'($urandom_range(0, 600)) - 300)));
      write_reg(REG_SETBACK, maybe_raw(16'($urandom_range(0, 500))));
      write_reg(REG_FLOW_MIN, maybe_raw(16'(fmin)));
      write_reg(REG_FLOW_MAX, maybe_raw(16'($urandom_range(fmin + 500, 1500))));
      write_reg(REG_PROP_GAIN, maybe_raw(16'($urandom_range(0, 1024))));
      write_reg(REG_INTEGRAL_GAIN, maybe_raw(16'($urandom_range(0, 256))));
      write_reg(REG_HEAT_START, maybe_raw(16'(int'($urandom_range(0, 600)) - 300)));
      settings_used++;
   endtask

   task automatic queue_random_ticks(int n);
      @(negedge clock);
      repeat (n) tick_q.push_back(random_tick());
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (tick_q.size() != 0 || req_ch.valid || expected_ctrl_q.size() != 0);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.outdoor_temp = '0;
      req_ch.outdoor_average = '0;
      req_ch.flow_temp = '0;
      req_ch.room_setpoint = '0;
      req_ch.reduced_mode = 1'b0;
      req_ch.party_active = 1'b0;
      rsp_ch.ready = 1'b0;
   end

   // sender: bursts of items with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_ctrl_q.push_back(compute_control(cur_tick));
            ticks_sent++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (tick_q.size() != 0) begin
               cur_tick = tick_q.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.outdoor_temp <= cur_tick.outdoor;
               req_ch.outdoor_average <= cur_tick.average;
               req_ch.flow_temp <= cur_tick.flow;
               req_ch.room_setpoint <= cur_tick.room;
               req_ch.reduced_mode <= cur_tick.reduced;
               req_ch.party_active <= cur_tick.party;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // receiver: ready pacing switches at random between always, random and sparse
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            rx_pace = rx_pace_type'($urandom_range(0, 2));
            stall_left = $urandom_range(20, 300);
         end else begin
            stall_left--;
         end
         case (rx_pace)
            RX_ALWAYS: rsp_ch.ready <= 1'b1;
            RX_RANDOM: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            default:   rsp_ch.ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   always @(posedge clock) begin : check_rsp
      ctrl_out_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_ctrl_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: setpoint %0d valve %0d pump %0b",
                        rsp_ch.flow_setpoint, rsp_ch.valve_position, rsp_ch.pump_on);
         end else begin
            want = expected_ctrl_q.pop_front();
            if (rsp_ch.flow_setpoint !== want.setpoint ||
                rsp_ch.valve_position !== want.valve ||
                rsp_ch.pump_on !== want.pump) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("result %0d: expected sp %0d valve %0d pump %0b",
                           results_checked, want.setpoint, want.valve, want.pump);
                  $display("   got sp %0d valve %0d pump %0b",
                           rsp_ch.flow_setpoint, rsp_ch.valve_position, rsp_ch.pump_on);
               end
            end
            results_checked++;
            if (want.pump)
               pump_on_count++;
            if (want.valve == '0 || want.valve == DRIVE_MAX)
               saturated_count++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                  idle_cycles, expected_ctrl_q.size());
         $display("heating_curve_pi_mixer_control regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      csr_ch.valid = 1'b0;
      csr_ch.index = REG_CURVE_SLOPE;
      csr_ch.data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed items on reset settings
      @(negedge clock);
      tick_q.push_back(make_tick(0, 100, 300, 200, 0, 0));
      tick_q.push_back(make_tick(-2048, -2048, -2048, 511, 1, 0));   // all-ones room, min patterns
      tick_q.push_back(make_tick(2047, 2047, 2047, 0, 0, 0));        // max patterns
      tick_q.push_back(make_tick(-500, -500, -500, 400, 0, 1));
      tick_q.push_back(make_tick(1500, 1500, 1500, 0, 1, 1));
      tick_q.push_back(make_tick(100, 100, 350, 210, 1, 1));         // party cancels setback
      tick_q.push_back(make_tick(100, 100, 350, 210, 1, 0));         // setback applied
      tick_q.push_back(make_tick(100, 100, 350, 210, 0, 1));
      tick_q.push_back(make_tick(100, 155, 300, 210, 0, 0));         // inside band: hold
      tick_q.push_back(make_tick(100, 170, 300, 210, 0, 0));         // above band: off
      tick_q.push_back(make_tick(29, 160, 300, 210, 0, 0));          // frost: on
      tick_q.push_back(make_tick(30, 161, 300, 210, 0, 0));          // off
      tick_q.push_back(make_tick(30, 155, 300, 210, 0, 0));          // hold off
      tick_q.push_back(make_tick(190, 149, 200, 195, 0, 0));         // setpoint exactly 200
      tick_q.push_back(make_tick(400, 149, 200, 400, 0, 0));         // start
      tick_q.push_back(make_tick(400, 149, 400, 400, 0, 0));         // zero error
      tick_q.push_back(make_tick(1000, 300, 1500, 0, 0, 0));         // low clamp, drive to zero
      wait_drained();

      // extremes: high curve offset and gains, wide limits
      program_setting(0, 300, 500, -500, 1500, 65535, 65535, 300);
      queue_random_ticks(EXTREME_TICKS);
      wait_drained();

      // extremes: steepest curve, inverted limits, no gain
      program_setting(2047, -300, 0, 1500, -500, 0, 0, -300);
      queue_random_ticks(EXTREME_TICKS);
      wait_drained();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         program_random_setting();
         if (p == 2) begin
            // let the pipe run dry mid-phase
            queue_random_ticks(PHASE_TICKS / 2);
            wait_drained();
            queue_random_ticks(PHASE_TICKS - PHASE_TICKS / 2);
         end else begin
            queue_random_ticks(PHASE_TICKS);
         end
         wait_drained();
      end

      $display("covered %0d ticks over %0d register settings, %0d results checked",
               ticks_sent, settings_used, results_checked);
      $display("pump on in %0d results, valve at a limit in %0d, %0d mismatches",
               pump_on_count, saturated_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("heating_curve_pi_mixer_control regression: pass");
      end else begin
         $display("heating_curve_pi_mixer_control regression: fail");
      end
      $finish;
   end

endmodule
